@@ sv/ils_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants and action/status codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_VALUE_BITS = 32;

   localparam int ACTION_BITS   = 3;
   localparam int POSITION_BITS = 7;
   localparam int VALUE_IN_BITS = 32;
   localparam int STATUS_BITS   = 3;
   localparam int RESULT_BITS   = 32;
   localparam int TOTAL_BITS    = 38;
   localparam int COUNT_BITS    = 7;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_READ   = 3'd2,
      ACT_FIND   = 3'd3,
      ACT_CLEAR  = 3'd4,
      ACT_STATS  = 3'd5
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK     = 3'd0,
      ST_BADPOS = 3'd1,
      ST_FULL   = 3'd2,
      ST_MISS   = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

endpackage

@@ sv/ils_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ sv/indexed_list_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded ordered list of values with insert/remove/read/find/clear/stats.
// ----------------------------------------------------------------------------
// Usage: present a request on req_action/req_position/req_value with
// req_valid; it is taken when req_ready is high. Exactly one response comes
// back on the rsp_ channel per request, held until rsp_ready.
// Entries live in one RAM with registered read data. Clear, unused
// action codes and errors answer without touching the RAM; read fetches
// one entry; insert and remove shift the later entries by one place;
// find scans from position 0 until a match; statistics scans every entry,
// then a restoring divider forms the mean from the total.
// The block takes one request at a time; req_ready rises when the previous
// response has been loaded into the output register, so a new request may
// be worked on while that response waits for rsp_ready, and the result is
// handed over once the output register frees up.
// Reset clears the entry count; the RAM needs no clearing pass because only
// positions below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
   parameter int CAPACITY   = ils_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = ils_pkg::DEF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ils_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [ils_pkg::POSITION_BITS-1:0] req_position,
   input  logic [ils_pkg::VALUE_IN_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ils_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [ils_pkg::RESULT_BITS-1:0]   rsp_result_value,
   output logic [ils_pkg::TOTAL_BITS-1:0]    rsp_total,
   output logic [ils_pkg::RESULT_BITS-1:0]   rsp_smallest,
   output logic [ils_pkg::RESULT_BITS-1:0]   rsp_largest,
   output logic [ils_pkg::RESULT_BITS-1:0]   rsp_mean,
   output logic [ils_pkg::COUNT_BITS-1:0]    rsp_entry_count
);
   import ils_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DIV_STEPS = TOTAL_BITS;
   localparam int DCW = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_MOVE, S_SCAN, S_DIV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [ACTION_BITS-1:0]  act_ff, act_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;     // address issued to RAM
   logic                    rdv_ff, rdv_in;     // RAM read data valid
   logic [STATUS_BITS-1:0]  st_ff, st_in;
   logic [RESULT_BITS-1:0]  res_ff, res_in;
   logic [TOTAL_BITS-1:0]   tot_ff, tot_in;
   logic [VALUE_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [TOTAL_BITS-1:0]   quo_ff, quo_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [DCW-1:0]          dstep_ff, dstep_in;

   logic                    pend_ff, pend_in;   // result ready to load output

   logic                    out_v_ff, out_v_in;
   logic [STATUS_BITS-1:0]  o_st_ff, o_st_in;
   logic [RESULT_BITS-1:0]  o_res_ff, o_res_in;
   logic [TOTAL_BITS-1:0]   o_tot_ff, o_tot_in;
   logic [RESULT_BITS-1:0]  o_lo_ff, o_lo_in, o_hi_ff, o_hi_in, o_mean_ff, o_mean_in;
   logic [COUNT_BITS-1:0]   o_cnt_ff, o_cnt_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [VALUE_BITS-1:0]   wr_data, rd_data;

   ils_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   function automatic logic [RESULT_BITS-1:0] widen(input logic [VALUE_BITS-1:0] v);
      logic [RESULT_BITS+VALUE_BITS-1:0] t;
      t = {{RESULT_BITS{1'b0}}, v};
      return t[RESULT_BITS-1:0];
   endfunction

   logic [CW:0]           rem_shift;
   logic [TOTAL_BITS-1:0] tot_add;
   logic [CW-1:0]         idx_prev;

   assign req_ready = (state_ff == S_IDLE) && !pend_ff;
   assign idx_prev  = idx_ff - CW'(1);
   assign rem_shift = {rem_ff, quo_ff[TOTAL_BITS-1]};
   assign tot_add   = tot_ff + TOTAL_BITS'(rd_data);

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      rdv_in   = 1'b0;
      st_in    = st_ff;
      res_in   = res_ff;
      tot_in   = tot_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dstep_in = dstep_ff;
      pend_in  = pend_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = val_ff;
      rd_addr  = idx_ff[AW-1:0];

      out_v_in  = out_v_ff;
      o_st_in   = o_st_ff;
      o_res_in  = o_res_ff;
      o_tot_in  = o_tot_ff;
      o_lo_in   = o_lo_ff;
      o_hi_in   = o_hi_ff;
      o_mean_in = o_mean_ff;
      o_cnt_in  = o_cnt_ff;

      if (out_v_ff && rsp_ready) begin
         out_v_in = 1'b0;
      end
      // load output register from pending result
      if (pend_ff && (!out_v_ff || rsp_ready)) begin
         pend_in   = 1'b0;
         out_v_in  = 1'b1;
         o_st_in   = st_ff;
         o_res_in  = res_ff;
         o_tot_in  = (act_ff == ACT_STATS && st_ff == ST_OK) ? tot_ff : '0;
         o_lo_in   = (act_ff == ACT_STATS && st_ff == ST_OK) ? widen(lo_ff) : '0;
         o_hi_in   = (act_ff == ACT_STATS && st_ff == ST_OK) ? widen(hi_ff) : '0;
         o_mean_in = (act_ff == ACT_STATS && st_ff == ST_OK) ? quo_ff[RESULT_BITS-1:0] : '0;
         o_cnt_in  = COUNT_BITS'(count_ff);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               act_in   = req_action;
               pos_in   = (CW >= POSITION_BITS) ? CW'(req_position)
                        : ((|(req_position >> CW)) ? '1 : CW'(req_position));
               val_in   = VALUE_BITS'(req_value);
               st_in    = ST_OK;
               res_in   = '0;
               tot_in   = '0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_INSERT: begin
                  if (count_ff == CW'(CAPACITY)) st_in = ST_FULL;
                  else if (pos_ff > count_ff) st_in = ST_BADPOS;
                  else begin
                     idx_in = count_ff;   // next slot to fill, walk downward
                     state_in = S_MOVE;
                  end
               end
               ACT_REMOVE, ACT_READ: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (pos_ff >= count_ff) st_in = ST_BADPOS;
                  else begin
                     idx_in = (act_ff == ACT_REMOVE) ? pos_ff + CW'(1) : pos_ff;
                     state_in = (act_ff == ACT_REMOVE) ? S_MOVE : S_SCAN;
                  end
               end
               ACT_FIND, ACT_STATS: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else begin
                     idx_in = '0;
                     state_in = S_SCAN;
                     if (act_ff == ACT_FIND) st_in = ST_MISS;
                  end
               end
               ACT_CLEAR: count_in = '0;
               default: ;
            endcase
         end
         S_MOVE: begin
            if (act_ff == ACT_INSERT) begin
               // read idx-1 issued last cycle lands now; write into idx
               if (idx_ff == pos_ff) begin
                  wr_en = 1'b1; wr_data = val_ff; wr_addr = idx_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
                  state_in = S_DONE;
               end else begin
                  rd_addr = idx_prev[AW-1:0];
                  if (rdv_ff) begin
                     wr_en = 1'b1; wr_data = rd_data; wr_addr = idx_ff[AW-1:0];
                     idx_in = idx_prev;
                  end else begin
                     rdv_in = 1'b1;
                  end
               end
            end else begin
               // remove: copy idx into idx-1
               if (idx_ff == count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end else begin
                  rd_addr = idx_ff[AW-1:0];
                  if (rdv_ff) begin
                     wr_en = 1'b1; wr_data = rd_data; wr_addr = idx_prev[AW-1:0];
                     idx_in = idx_ff + CW'(1);
                  end else begin
                     rdv_in = 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            // address idx issued; rdv_ff: data for idx-1 (read: idx)
            if (idx_ff < count_ff) begin
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
               rdv_in  = 1'b1;
            end
            if (rdv_ff) begin
               if (act_ff == ACT_READ) begin
                  res_in = widen(rd_data);
                  rdv_in = 1'b0;
                  state_in = S_DONE;
               end else if (act_ff == ACT_FIND) begin
                  if (rd_data == val_ff) begin
                     st_in = ST_OK;
                     res_in = RESULT_BITS'(idx_prev);
                     rdv_in = 1'b0;
                     state_in = S_DONE;
                  end else if (idx_ff == count_ff) begin
                     rdv_in = 1'b0;
                     state_in = S_DONE;
                  end
               end else begin
                  tot_in = tot_add;
                  if (idx_prev == '0) begin
                     lo_in = rd_data; hi_in = rd_data;
                  end else begin
                     if (rd_data < lo_ff) lo_in = rd_data;
                     if (rd_data > hi_ff) hi_in = rd_data;
                  end
                  if (idx_ff == count_ff) begin
                     rdv_in   = 1'b0;
                     quo_in   = tot_add;
                     rem_in   = '0;
                     dstep_in = '0;
                     state_in = S_DIV;
                  end
               end
            end
            if (act_ff == ACT_READ && !rdv_ff) begin
               idx_in = idx_ff;   // single read only
               rdv_in = 1'b1;
            end
         end
         S_DIV: begin
            // restoring divide of quo by count, one quotient bit a cycle
            if (rem_shift >= {1'b0, count_ff}) begin
               rem_in = CW'(rem_shift - {1'b0, count_ff});
               quo_in = {quo_ff[TOTAL_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[CW-1:0];
               quo_in = {quo_ff[TOTAL_BITS-2:0], 1'b0};
            end
            dstep_in = dstep_ff + DCW'(1);
            if (dstep_ff == DCW'(DIV_STEPS - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            pend_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         out_v_ff <= out_v_in;
         rdv_ff   <= rdv_in;
      end
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      st_ff     <= st_in;
      res_ff    <= res_in;
      tot_ff    <= tot_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dstep_ff  <= dstep_in;
      o_st_ff   <= o_st_in;
      o_res_ff  <= o_res_in;
      o_tot_ff  <= o_tot_in;
      o_lo_ff   <= o_lo_in;
      o_hi_ff   <= o_hi_in;
      o_mean_ff <= o_mean_in;
      o_cnt_ff  <= o_cnt_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_status       = o_st_ff;
   assign rsp_result_value = o_res_ff;
   assign rsp_total        = o_tot_ff;
   assign rsp_smallest     = o_lo_ff;
   assign rsp_largest      = o_hi_ff;
   assign rsp_mean         = o_mean_ff;
   assign rsp_entry_count  = o_cnt_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_MOVE && state_ff != S_DECIDE) |=> $stable(count_ff))
      else $error("count changed outside update");
   a_no_wr_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_MOVE) else $error("RAM write outside move");
`endif

endmodule
